// File: rtl/dhcp_option_field_scanner_defines.svh
// Assertion helpers shared by the scanner RTL.
`ifndef DHCP_OPTION_FIELD_SCANNER_DEFINES_SVH
`define DHCP_OPTION_FIELD_SCANNER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DOFS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scanner assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define DOFS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scanner assertion failed");

`endif

// File: rtl/dofs_pkg.sv
package dofs_pkg;

    typedef enum logic [3:0] {
        PH_CODE = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_OVER = 4'b0100,
        PH_SKIP = 4'b1000
    } phase_t;

    localparam logic [1:0] AREA_OPTIONS = 2'd0;
    localparam logic [1:0] AREA_FILE    = 2'd1;
    localparam logic [1:0] AREA_SNAME   = 2'd2;

    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_ABSENT    = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;

    localparam logic [7:0] PAD_CODE      = 8'd0;
    localparam logic [7:0] END_CODE      = 8'd255;
    localparam logic [7:0] OVERLOAD_CODE = 8'd52;

    typedef struct packed {
        phase_t     phase;
        logic [8:0] pos;
        logic [7:0] skip;
        logic [1:0] flags;
        logic [1:0] active_area;
        logic       finished;
        logic [7:0] target;
        logic [7:0] pending;
    } scan_state_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] status;
        logic [1:0] area;
        logic [8:0] offset;
        logic [7:0] length;
    } scan_result_t;

endpackage

// File: rtl/dhcp_option_field_scanner.sv
// DHCP option field scanner.
// Input channel (in_valid/in_ready): one message byte per transfer with its
// area code, a message_start flag on the first options byte, and the sought
// option code, which is sampled with message_start.
// Output channel (out_valid/out_ready): one result per message: status
// found, not present or malformed, and for found the area, data offset and
// length byte of the option.
// Path: a byte passes an input register and the scan logic into the result
// register, from which its result is offered on out.
// Throughput: one byte per cycle while no stalled result holds the input;
// the scan state update is a single registered step per byte.
// Reset: no scan is open, every byte is ignored until a message_start.
// A stalled result holds in the output register; an empty input register
// still takes a byte, then in_ready drops until the result is transferred.
`include "dhcp_option_field_scanner_defines.svh"

module dhcp_option_field_scanner #(
    parameter int OPTIONS_BYTES = 308,
    parameter int FILE_BYTES    = 128,
    parameter int SNAME_BYTES   = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic [1:0] area,
    input  logic       message_start,
    input  logic [7:0] sought_code,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [1:0] found_area,
    output logic [8:0] data_offset,
    output logic [7:0] data_length
);
    import dofs_pkg::*;

    localparam scan_state_t STATE_RESET = '{
        phase:       PH_CODE,
        pos:         9'd0,
        skip:        8'd0,
        flags:       2'd0,
        active_area: AREA_OPTIONS,
        finished:    1'b1,
        target:      8'd0,
        pending:     8'd0
    };

    logic         s1_valid_reg;
    logic [7:0]   s1_byte_reg;
    logic [1:0]   s1_area_reg;
    logic         s1_start_reg;
    logic [7:0]   s1_sought_reg;
    scan_state_t  state_reg;
    scan_state_t  state_next;
    scan_result_t res_next;
    logic         out_valid_reg;
    logic [1:0]   status_reg;
    logic [1:0]   found_area_reg;
    logic [8:0]   data_offset_reg;
    logic [7:0]   data_length_reg;
    logic         adv;
    logic         out_load;

    dofs_step #(
        .OPTIONS_BYTES (OPTIONS_BYTES),
        .FILE_BYTES    (FILE_BYTES),
        .SNAME_BYTES   (SNAME_BYTES)
    ) u_step (
        .state_cur     (state_reg),
        .data_byte     (s1_byte_reg),
        .area          (s1_area_reg),
        .message_start (s1_start_reg),
        .sought_code   (s1_sought_reg),
        .state_next    (state_next),
        .result        (res_next)
    );

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || adv;
    assign out_load = adv && s1_valid_reg && res_next.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg   <= data_byte;
            s1_area_reg   <= area;
            s1_start_reg  <= message_start;
            s1_sought_reg <= sought_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (adv && s1_valid_reg)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s1_valid_reg && res_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg      <= res_next.status;
            found_area_reg  <= res_next.area;
            data_offset_reg <= res_next.offset;
            data_length_reg <= res_next.length;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found_area  = found_area_reg;
    assign data_offset = data_offset_reg;
    assign data_length = data_length_reg;

    // Input side only stalls behind a full input register and a blocked result.
    `DOFS_ASSERT_IMP(a_ready_stall, !in_ready, s1_valid_reg && out_valid_reg && !out_ready)
    // A result closes the scan.
    `DOFS_ASSERT_NEXT(a_result_closes, out_load, state_reg.finished)
    // Only found results carry location fields.
    `DOFS_ASSERT_IMP(a_nonfound_zero, out_valid_reg && status_reg != ST_FOUND,
        found_area_reg == AREA_OPTIONS && data_offset_reg == 9'd0 && data_length_reg == 8'd0)
    // Status codes stay within the defined set.
    `DOFS_ASSERT_IMP(a_status_code, out_valid_reg,
        status_reg == ST_FOUND || status_reg == ST_ABSENT || status_reg == ST_MALFORMED)

endmodule

// File: rtl/dofs_step.sv
module dofs_step #(
    parameter int OPTIONS_BYTES = 308,
    parameter int FILE_BYTES    = 128,
    parameter int SNAME_BYTES   = 64
) (
    input  dofs_pkg::scan_state_t  state_cur,
    input  logic [7:0]             data_byte,
    input  logic [1:0]             area,
    input  logic                   message_start,
    input  logic [7:0]             sought_code,
    output dofs_pkg::scan_state_t  state_next,
    output dofs_pkg::scan_result_t result
);
    import dofs_pkg::*;

    localparam logic [9:0] OPT_LIM   = 10'(OPTIONS_BYTES);
    localparam logic [9:0] FILE_LIM  = 10'(FILE_BYTES);
    localparam logic [9:0] SNAME_LIM = 10'(SNAME_BYTES);

    scan_state_t eff;
    logic [9:0]  lim;
    logic [9:0]  pos_ext;
    logic [9:0]  run_end;
    logic [9:0]  pos_inc;
    logic [7:0]  skip_dec;
    logic [1:0]  next_area;
    logic        has_next;
    logic        hold_pos;

    // A start clears the scan before this byte is looked at.
    always_comb
    begin
        eff = state_cur;
        if (message_start)
        begin
            eff.phase       = PH_CODE;
            eff.pos         = '0;
            eff.skip        = '0;
            eff.flags       = '0;
            eff.active_area = AREA_OPTIONS;
            eff.pending     = '0;
            eff.target      = sought_code;
            eff.finished    = 1'b0;
        end
    end

    always_comb
    begin
        case (eff.active_area)
            AREA_OPTIONS: lim = OPT_LIM;
            AREA_FILE:    lim = FILE_LIM;
            default:      lim = SNAME_LIM;
        endcase
        pos_ext  = {1'b0, eff.pos};
        run_end  = pos_ext + {2'b00, data_byte};
        pos_inc  = pos_ext + 10'd1;
        skip_dec = eff.skip - 8'd1;
        has_next = 1'b0;
        next_area = AREA_SNAME;
        if (eff.active_area == AREA_OPTIONS && eff.flags[0])
        begin
            has_next  = 1'b1;
            next_area = AREA_FILE;
        end
        else if (eff.active_area != AREA_SNAME && eff.flags[1])
        begin
            has_next  = 1'b1;
            next_area = AREA_SNAME;
        end
    end

    always_comb
    begin
        state_next = eff;
        result     = '0;
        hold_pos   = 1'b0;
        if (!eff.finished && area == eff.active_area)
        begin
            case (eff.phase)
                PH_CODE:
                begin
                    if (data_byte == eff.target || !(data_byte inside {PAD_CODE, END_CODE}))
                    begin
                        state_next.pending = data_byte;
                        state_next.phase   = PH_LEN;
                    end
                    else if (data_byte == END_CODE)
                    begin
                        hold_pos = 1'b1;
                        if (has_next)
                        begin
                            state_next.active_area = next_area;
                            state_next.pos         = '0;
                        end
                        else
                        begin
                            result.valid = 1'b1;
                            result.status = ST_ABSENT;
                        end
                    end
                end
                PH_LEN:
                begin
                    if (eff.pending == eff.target)
                    begin
                        hold_pos     = 1'b1;
                        result.valid = 1'b1;
                        if (run_end >= lim)
                        begin
                            result.status = ST_MALFORMED;
                        end
                        else
                        begin
                            result.status = ST_FOUND;
                            result.area   = eff.active_area;
                            result.offset = pos_inc[8:0];
                            result.length = data_byte;
                        end
                    end
                    else if (eff.pending == OVERLOAD_CODE && run_end >= lim)
                    begin
                        hold_pos      = 1'b1;
                        result.valid  = 1'b1;
                        result.status = ST_MALFORMED;
                    end
                    else
                    begin
                        state_next.skip = data_byte;
                        if (data_byte == 8'd0)
                            state_next.phase = PH_CODE;
                        else if (eff.pending == OVERLOAD_CODE)
                            state_next.phase = PH_OVER;
                        else
                            state_next.phase = PH_SKIP;
                    end
                end
                PH_OVER:
                begin
                    state_next.flags = data_byte[1:0];
                    state_next.skip  = skip_dec;
                    state_next.phase = (skip_dec != 8'd0) ? PH_SKIP : PH_CODE;
                end
                default:
                begin
                    state_next.skip = skip_dec;
                    if (skip_dec == 8'd0)
                        state_next.phase = PH_CODE;
                end
            endcase

            // Area runs out on its last byte while the scan is still open.
            if (!hold_pos)
            begin
                if (pos_inc >= lim)
                begin
                    result.valid  = 1'b1;
                    result.status = ST_MALFORMED;
                end
                else
                begin
                    state_next.pos = pos_inc[8:0];
                end
            end

            if (result.valid)
                state_next.finished = 1'b1;
        end
    end

endmodule

// File: tb/tb_dhcp_option_field_scanner.sv
`timescale 1ns / 1ps

module tb_dhcp_option_field_scanner;
    import dofs_pkg::*;

    localparam int OPTIONS_BYTES = 308;
    localparam int FILE_BYTES    = 128;
    localparam int SNAME_BYTES   = 64;
    localparam int SCAN_TARGET   = 1900;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int MAX_WAIT      = 14;
    localparam int DRAIN_CYCLES  = 20;
    localparam int SIDE_IN       = 0;
    localparam int SIDE_OUT      = 1;
    localparam logic [1:0] AREA_UNUSED = 2'd3;

    typedef struct {
        logic [1:0] status;
        logic [1:0] area;
        logic [8:0] offset;
        logic [7:0] length;
    } scan_outcome_t;

    class scan_scoreboard;
        phase_t        scan_phase;
        int            pos;
        logic [7:0]    skip;
        logic [1:0]    flags;
        logic [1:0]    cur_area;
        bit            done;
        logic [7:0]    target;
        logic [7:0]    pending;
        scan_outcome_t outcomes[$];
        int            errors;
        int            scanned;
        int            messages;
        int            n_found;
        int            n_absent;
        int            n_malformed;

        function new();
            clear_scan();
            done = 1'b1;
            target = 8'd0;
        endfunction

        function void clear_scan();
            scan_phase = PH_CODE;
            pos = 0;
            skip = 8'd0;
            flags = 2'd0;
            cur_area = AREA_OPTIONS;
            pending = 8'd0;
        endfunction

        function int area_bytes(logic [1:0] a);
            if (a == AREA_OPTIONS)
                return OPTIONS_BYTES;
            if (a == AREA_FILE)
                return FILE_BYTES;
            return SNAME_BYTES;
        endfunction

        function int outstanding();
            return outcomes.size();
        endfunction

        function void close_scan(logic [1:0] st, logic [1:0] ar, int off, logic [7:0] len);
            scan_outcome_t r;
            r.status = st;
            r.area = ar;
            r.offset = 9'(off);
            r.length = len;
            outcomes.push_back(r);
            done = 1'b1;
            case (st)
                ST_FOUND: n_found++;
                ST_ABSENT: n_absent++;
                default: n_malformed++;
            endcase
        endfunction

        // Advance the scan by one transferred byte; queue any result it causes.
        function void scan_byte(logic [7:0] d, logic [1:0] a, logic st, logic [7:0] sc);
            int lim;
            int p;
            if (st)
            begin
                clear_scan();
                target = sc;
                done = 1'b0;
                messages++;
            end
            if (done || a != cur_area)
                return;
            scanned++;
            lim = area_bytes(cur_area);
            p = pos;
            case (scan_phase)
                PH_CODE:
                begin
                    // the match test wins over pad and end handling
                    if (d == target || (d != PAD_CODE && d != END_CODE))
                    begin
                        pending = d;
                        scan_phase = PH_LEN;
                    end
                    else if (d == END_CODE)
                    begin
                        if (cur_area == AREA_OPTIONS && flags[0])
                            cur_area = AREA_FILE;
                        else if (cur_area != AREA_SNAME && flags[1])
                            cur_area = AREA_SNAME;
                        else
                        begin
                            close_scan(ST_ABSENT, AREA_OPTIONS, 0, 8'd0);
                            return;
                        end
                        pos = 0;
                        return;
                    end
                end
                PH_LEN:
                begin
                    if (pending == target)
                    begin
                        if (p + int'(d) >= lim)
                            close_scan(ST_MALFORMED, AREA_OPTIONS, 0, 8'd0);
                        else
                            close_scan(ST_FOUND, cur_area, p + 1, d);
                        return;
                    end
                    if (pending == OVERLOAD_CODE && p + int'(d) >= lim)
                    begin
                        close_scan(ST_MALFORMED, AREA_OPTIONS, 0, 8'd0);
                        return;
                    end
                    skip = d;
                    if (d == 8'd0)
                        scan_phase = PH_CODE;
                    else if (pending == OVERLOAD_CODE)
                        scan_phase = PH_OVER;
                    else
                        scan_phase = PH_SKIP;
                end
                PH_OVER:
                begin
                    flags = d[1:0];
                    skip = skip - 8'd1;
                    scan_phase = (skip != 8'd0) ? PH_SKIP : PH_CODE;
                end
                default:
                begin
                    skip = skip - 8'd1;
                    if (skip == 8'd0)
                        scan_phase = PH_CODE;
                end
            endcase
            // last byte of the area consumed with the scan still open
            if (p + 1 >= lim)
            begin
                close_scan(ST_MALFORMED, AREA_OPTIONS, 0, 8'd0);
                return;
            end
            pos = p + 1;
        endfunction

        function void check_result(scan_outcome_t got);
            scan_outcome_t want;
            if (outcomes.size() == 0)
            begin
                $error("result with none awaited: status %0d area %0d offset %0d length %0d",
                       got.status, got.area, got.offset, got.length);
                errors++;
                return;
            end
            want = outcomes.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.area !== want.area)
            begin
                $error("found_area: expected %0d, got %0d", want.area, got.area);
                errors++;
            end
            if (got.offset !== want.offset)
            begin
                $error("data_offset: expected %0d, got %0d", want.offset, got.offset);
                errors++;
            end
            if (got.length !== want.length)
            begin
                $error("data_length: expected %0d, got %0d", want.length, got.length);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_byte;
    logic [1:0] area;
    logic       message_start;
    logic [7:0] sought_code;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] status;
    logic [1:0] found_area;
    logic [8:0] data_offset;
    logic [7:0] data_length;

    scan_scoreboard board = new();
    int         burst_left[2];
    int         bytes_sent;
    int         cycle_count;
    logic [7:0] layout[$];

    dhcp_option_field_scanner #(
        .OPTIONS_BYTES(OPTIONS_BYTES),
        .FILE_BYTES(FILE_BYTES),
        .SNAME_BYTES(SNAME_BYTES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .data_byte(data_byte),
        .area(area),
        .message_start(message_start),
        .sought_code(sought_code),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .found_area(found_area),
        .data_offset(data_offset),
        .data_length(data_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $error("cycle limit reached with %0d results outstanding", board.outstanding());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Wait count for one transfer; now and then a run of back-to-back transfers.
    function automatic int draw_wait(int side);
        if (burst_left[side] > 0)
        begin
            burst_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            burst_left[side] = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic send_byte(input logic [7:0] d, input logic [1:0] a, input logic st,
                             input logic [7:0] sc);
        int gap;
        gap = draw_wait(SIDE_IN);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= d;
        area <= a;
        message_start <= st;
        sought_code <= sc;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        bytes_sent++;
        board.scan_byte(d, a, st, sc);
    endtask

    // Drive one message area by area; drop the rest a few bytes after its result.
    task automatic run_message(input logic [7:0] target, input logic [7:0] opt[$],
                               input logic [7:0] fil[$], input logic [7:0] snm[$],
                               input bit noisy);
        logic [7:0] q[$];
        int tail;
        bit first;
        tail = $urandom_range(0, 3);
        first = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            case (a)
                0: q = opt;
                1: q = fil;
                default: q = snm;
            endcase
            foreach (q[i])
            begin
                if (noisy && $urandom_range(0, 39) == 0)
                    send_byte(8'($urandom), AREA_UNUSED, 1'b0, 8'($urandom));
                send_byte(q[i], 2'(a), first, first ? target : 8'($urandom));
                first = 1'b0;
                if (board.done)
                begin
                    if (tail == 0)
                        return;
                    tail--;
                end
            end
        end
    endtask

    function automatic logic [7:0] filler_code(input logic [7:0] target);
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 254));
        while (c == target || c == OVERLOAD_CODE);
        return c;
    endfunction

    function automatic void add_option(input logic [7:0] code, input int len);
        layout.push_back(code);
        layout.push_back(8'(len));
        repeat (len) layout.push_back(8'($urandom));
    endfunction

    function automatic void add_overload();
        int len;
        len = $urandom_range(0, 3);
        layout.push_back(OVERLOAD_CODE);
        layout.push_back(8'(len));
        if (len > 0)
            layout.push_back(8'($urandom));
        repeat (len - 1) layout.push_back(8'($urandom));
    endfunction

    // Fill layout with one area: filler options and pads, maybe the sought option
    // and an overload option, then an end byte; or, with no end byte, run past the area end.
    function automatic void build_area(input logic [7:0] target, input int lim,
                                       input bit with_target, input bit with_overload);
        int n;
        int t_at;
        int o_at;
        int lead;
        bit exhaust;
        layout.delete();
        n = $urandom_range(0, 5);
        t_at = $urandom_range(0, n);
        o_at = $urandom_range(0, n);
        exhaust = ($urandom_range(0, 11) == 0);
        lead = 0;
        if (exhaust)
            lead = lim;
        else if ($urandom_range(0, 7) == 0)
            lead = $urandom_range(0, lim - 20);
        while (layout.size() < lead)
            add_option(filler_code(target), $urandom_range(0, 20));
        for (int i = 0; i <= n; i++)
        begin
            if (with_overload && i == o_at)
                add_overload();
            if (with_target && i == t_at)
                add_option(target, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                               : $urandom_range(0, 12));
            if (i < n)
            begin
                if (target != PAD_CODE && $urandom_range(0, 4) == 0)
                    layout.push_back(PAD_CODE);
                else
                    add_option(filler_code(target), $urandom_range(0, 8));
            end
        end
        if (!exhaust)
            layout.push_back(END_CODE);
    endfunction

    function automatic logic [7:0] pick_target();
        case ($urandom_range(0, 9))
            0: return PAD_CODE;
            1: return END_CODE;
            2: return OVERLOAD_CODE;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_noise();
        int n;
        int a;
        bit st;
        n = $urandom_range(1, 40);
        for (int i = 0; i < n; i++)
        begin
            a = $urandom_range(0, 5);
            if (i == 0)
                st = ($urandom_range(0, 3) != 0);
            else
                st = ($urandom_range(0, 19) == 0);
            send_byte(8'($urandom), (a > 3) ? AREA_OPTIONS : 2'(a), st, 8'($urandom));
        end
    endtask

    task automatic run_random_message();
        logic [7:0] opt[$];
        logic [7:0] fil[$];
        logic [7:0] snm[$];
        logic [7:0] target;
        int place;
        int kind;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            send_noise();
            return;
        end
        target = pick_target();
        place = $urandom_range(0, 3);
        build_area(target, OPTIONS_BYTES, place == 0, $urandom_range(0, 3) != 0);
        opt = layout;
        build_area(target, FILE_BYTES, place == 1, $urandom_range(0, 5) == 0);
        fil = layout;
        build_area(target, SNAME_BYTES, place == 2, $urandom_range(0, 5) == 0);
        snm = layout;
        // corrupt a few options bytes
        if (kind == 1)
            repeat ($urandom_range(1, 3))
                opt[$urandom_range(0, opt.size() - 1)] = 8'($urandom);
        run_message(target, opt, fil, snm, 1'b1);
    endtask

    task automatic run_directed();
        logic [7:0] opt[$];
        logic [7:0] fil[$];
        logic [7:0] snm[$];

        // nothing is scanned before the first message start
        send_byte(8'd1, AREA_OPTIONS, 1'b0, 8'd1);
        send_byte(8'd255, AREA_SNAME, 1'b0, 8'd255);

        // sought pad code matches the pad byte itself
        opt = '{PAD_CODE, 8'd0, END_CODE};
        run_message(PAD_CODE, opt, fil, snm, 1'b0);

        // sought end code matches the end byte
        opt = '{8'd1, 8'd1, 8'hAA, END_CODE, 8'd3, 8'd1, 8'd2, 8'd3};
        run_message(END_CODE, opt, fil, snm, 1'b0);

        // sought overload code is a plain match
        opt = '{PAD_CODE, OVERLOAD_CODE, 8'd2, 8'd1, 8'd0, END_CODE};
        run_message(OVERLOAD_CODE, opt, fil, snm, 1'b0);

        // not present in the options area alone
        opt = '{PAD_CODE, 8'd9, 8'd1, 8'h55, END_CODE};
        run_message(8'd7, opt, fil, snm, 1'b0);

        // zero-length overload leaves the flags clear
        opt = '{OVERLOAD_CODE, 8'd0, END_CODE};
        fil = '{8'd7, 8'd1, 8'd0, END_CODE};
        run_message(8'd7, opt, fil, snm, 1'b0);

        // both extra areas, found in server name
        opt = '{OVERLOAD_CODE, 8'd1, 8'hFF, END_CODE};
        fil = '{8'd3, 8'd0, END_CODE};
        snm = '{PAD_CODE, 8'd66, 8'd4, 8'd1, 8'd2, 8'd3, 8'd4, END_CODE};
        run_message(8'd66, opt, fil, snm, 1'b0);

        // server name only; file bytes are ignored
        opt = '{OVERLOAD_CODE, 8'd2, 8'h02, 8'h01, END_CODE};
        fil = '{8'd66, 8'd1, 8'd0, END_CODE};
        snm = '{8'd66, 8'd0, END_CODE};
        run_message(8'd66, opt, fil, snm, 1'b0);

        // a later overload option overrides an earlier one
        opt = '{OVERLOAD_CODE, 8'd1, 8'd1, OVERLOAD_CODE, 8'd1, 8'd2, END_CODE};
        snm = '{8'd66, 8'd1, 8'd9, END_CODE};
        run_message(8'd66, opt, fil, snm, 1'b0);

        // found option overruns the server name area
        opt = '{OVERLOAD_CODE, 8'd1, 8'd2, END_CODE};
        fil.delete();
        snm = '{8'd66, 8'd64, 8'd0};
        run_message(8'd66, opt, fil, snm, 1'b0);

        // overload option overruns the server name area
        snm = '{OVERLOAD_CODE, 8'd64, 8'd0};
        run_message(8'd66, opt, fil, snm, 1'b0);

        // longest length byte, found early in the options area
        opt = '{8'd200, 8'd255, 8'h5A};
        snm.delete();
        run_message(8'd200, opt, fil, snm, 1'b0);

        // start on a file byte, then an unused-area byte; both ignored
        send_byte(8'd66, AREA_FILE, 1'b1, 8'd66);
        send_byte(8'hF0, AREA_UNUSED, 1'b0, 8'h0F);
        send_byte(8'd66, AREA_OPTIONS, 1'b0, 8'd0);
        send_byte(8'd5, AREA_OPTIONS, 1'b0, 8'd0);

        // restart in the middle of an option
        send_byte(8'd9, AREA_OPTIONS, 1'b1, 8'd1);
        send_byte(8'd1, AREA_OPTIONS, 1'b0, 8'd0);
        send_byte(8'd9, AREA_OPTIONS, 1'b1, 8'd9);
        send_byte(8'd2, AREA_OPTIONS, 1'b0, 8'd0);
    endtask

    initial
    begin : result_sink
        int stall;
        scan_outcome_t got;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_wait(SIDE_OUT);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            got.status = status;
            got.area = found_area;
            got.offset = data_offset;
            got.length = data_length;
            board.check_result(got);
        end
    end

    initial
    begin : stimulus
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        data_byte <= 8'd0;
        area <= AREA_OPTIONS;
        message_start <= 1'b0;
        sought_code <= 8'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        while (bytes_sent < SCAN_TARGET)
            run_random_message();
        in_valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d bytes, %0d of them scanned, across %0d message starts",
                 bytes_sent, board.scanned, board.messages);
        $display("Results: %0d found, %0d not present, %0d malformed",
                 board.n_found, board.n_absent, board.n_malformed);
        if (board.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: dhcp_option_field_scanner.f
+incdir+rtl
rtl/dofs_pkg.sv
rtl/dofs_step.sv
rtl/dhcp_option_field_scanner.sv
tb/tb_dhcp_option_field_scanner.sv
